// ===== sv/mpqs_pkg.sv =====
// shared types and constants for the ready queue scheduler
package mpqs_pkg;

	localparam int QueueDepth = 32;
	localparam int IdxW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	localparam logic [2:0] ModeFifo = 3'd0;
	localparam logic [2:0] ModeSjf  = 3'd1;
	localparam logic [2:0] ModeSrtf = 3'd2;
	localparam logic [2:0] ModeRr   = 3'd3;
	localparam logic [2:0] ModePrio = 3'd4;

	localparam logic [1:0] CurRunning = 2'd1;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] lifespan;
		logic [15:0] age;
		logic [7:0]  prio;
	} proc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_APPEND,
		ST_OUT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan_step;
		logic shift_start;
		logic shift_step;
		logic pop;
		logic append;
		logic enq;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_sched;
		logic keep;
		logic full;
		logic scan_done;
		logic shift_done;
		logic pick_table;
		logic with_cur;
	} stat_t;

	// true if b beats a under the given mode
	function automatic logic beats(input logic [2:0] mode, input proc_t a, input proc_t b);
		logic signed [16:0] ra;
		logic signed [16:0] rb;
		ra = $signed({1'b0, a.lifespan}) - $signed({1'b0, a.age});
		rb = $signed({1'b0, b.lifespan}) - $signed({1'b0, b.age});
		case (mode)
			ModeSjf:  beats = b.lifespan < a.lifespan;
			ModeSrtf: beats = rb < ra;
			ModePrio: beats = b.prio > a.prio;
			default:  beats = 1'b0;
		endcase
	endfunction

endpackage

// ===== sv/multi_policy_ready_queue_scheduler_core.sv =====
// top level of the multi-policy ready queue scheduler
// Usage:
// s_axis carries one word per item: enqueue a process or ask for a decision.
// m_axis returns one result word per item. The user is to make cfg writes to
// the policy register only while the block is idle; the block does not enforce it.
// An enqueue or a kept current process goes from acceptance through the
// scan state to the result register. A decision scans the table, and a live
// current under SRTF, RR or priority, through the registered table read,
// then closes the gap behind a removed entry, appends a live current and
// loads the result register.
// One item is in work at a time; s_axis_tready is high only when idle.
// While m_axis_tready is low the result register holds its word; the next
// item is taken and worked, then waits with s_axis_tready low until the
// register frees.
// Reset empties the table and sets the policy to FIFO; table contents are
// not cleared, only the count.
module multi_policy_ready_queue_scheduler_core import mpqs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// action, proc_id, proc_lifespan, proc_age, proc_prio, current_state, pad
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// picked_valid, picked_id, picked_age, picked_lifespan, picked_prio,
	// kept_current, dropped_full, queue_count, pad
	output logic [63:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);
	cmd_t cmd;
	stat_t st;
	logic out_busy;
	logic [2:0] mode_q;

	// policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= ModeFifo;
		else if (cfg_valid) mode_q <= cfg_data;
	end
	assign cfg_ready = 1'b1;

	mpqs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid && s_axis_tready),
		.out_busy(out_busy), .out_fire(m_axis_tvalid && m_axis_tready),
		.st(st), .cmd(cmd), .in_ready(s_axis_tready)
	);

	mpqs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .mode_in(mode_q),
		.in_word(s_axis_tdata[50:0]), .out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid), .out_word(m_axis_tdata),
		.out_busy(out_busy), .st(st)
	);
endmodule

// ===== sv/mpqs_ctrl.sv =====
// controller state machine for the ready queue scheduler
module mpqs_ctrl import mpqs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	input  logic  out_busy,
	input  logic  out_fire,
	input  stat_t st,
	output cmd_t  cmd,
	output logic  in_ready
);
	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_fire) state_d = ST_SCAN;
			ST_SCAN: begin
				if (!st.is_sched || st.keep) state_d = ST_OUT;
				else if (st.scan_done) state_d = st.pick_table ? ST_SHIFT : ST_OUT;
			end
			ST_SHIFT:  if (st.shift_done) state_d = st.with_cur ? ST_APPEND : ST_OUT;
			ST_APPEND: state_d = ST_OUT;
			ST_OUT:    if (!out_busy || out_fire) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_fire;
			end
			ST_SCAN: begin
				cmd.enq = !st.is_sched;
				cmd.scan_step = st.is_sched && !st.keep && !st.scan_done;
				cmd.shift_start = st.is_sched && !st.keep && st.scan_done && st.pick_table;
			end
			ST_SHIFT: begin
				cmd.shift_step = !st.shift_done;
				cmd.pop = st.shift_done;
			end
			ST_APPEND: cmd.append = 1'b1;
			ST_OUT:    cmd.finish = !out_busy || out_fire;
			default: ;
		endcase
	end

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_load_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_SCAN) else $error("no scan after load");
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == ST_IDLE) else $error("finish not idle");
`endif
endmodule

// ===== sv/mpqs_dp.sv =====
// datapath: ready table, scan, compaction and result register
module mpqs_dp import mpqs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [2:0]  mode_in,
	input  logic [50:0] in_word,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [63:0] out_word,
	output logic        out_busy,
	output stat_t       st
);
	proc_t mem [QueueDepth];
	proc_t cur_q, best_q, rd_q;
	logic [CntW-1:0] count_q, idx_q, best_i_q;
	logic [2:0] mode_q;
	logic sched_q, live_q, rd_ok_q, drop_q;
	logic [63:0] res_q;
	logic res_v_q;
	logic [CntW:0] n_cand;
	proc_t cand;
	logic [IdxW-1:0] rd_addr;
	logic wr_en;
	logic [IdxW-1:0] wr_addr;
	proc_t wr_data;
	logic picked;
	proc_t pk;

	assign st.is_sched = sched_q;
	assign st.keep = live_q && (mode_q == ModeFifo || mode_q == ModeSjf);
	assign st.with_cur = live_q && !st.keep;
	assign st.full = count_q == CntW'(QueueDepth);
	assign n_cand = {1'b0, count_q} + {{CntW{1'b0}}, st.with_cur};
	assign st.pick_table = best_i_q < count_q;
	assign st.scan_done = rd_ok_q && {1'b0, idx_q} >= n_cand;
	assign st.shift_done = ({1'b0, idx_q} + (CntW+1)'(1)) >= {1'b0, count_q};
	// candidate at the current scan position: table entry or current process
	assign cand = (idx_q < count_q) ? rd_q : cur_q;
	// scan reads idx ahead by one once primed, compaction reads idx+1 ahead by one
	assign rd_addr = idx_q[IdxW-1:0] + {{(IdxW-1){1'b0}}, cmd.shift_step}
		+ {{(IdxW-1){1'b0}}, rd_ok_q};

	// load, scan, compaction and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q <= ModeFifo;
			idx_q <= '0;
			best_i_q <= '0;
			rd_ok_q <= 1'b0;
			sched_q <= 1'b0;
			live_q <= 1'b0;
			drop_q <= 1'b0;
			cur_q <= '0;
			best_q <= '0;
		end else begin
			if (cmd.load) begin
				mode_q <= (mode_in > ModePrio) ? ModeFifo : mode_in;
				sched_q <= in_word[0];
				cur_q <= {in_word[8:1], in_word[24:9], in_word[40:25], in_word[48:41]};
				live_q <= in_word[50:49] == CurRunning && in_word[40:25] < in_word[24:9];
				idx_q <= '0;
				best_i_q <= '0;
				rd_ok_q <= 1'b0;
				drop_q <= 1'b0;
			end
			// read data from the table arrives in the cycle after the address
			if (cmd.scan_step) begin
				if (!rd_ok_q) begin
					rd_ok_q <= 1'b1;
				end else begin
					if (idx_q == '0 || beats(mode_q, best_q, cand)) begin
						best_q <= cand;
						best_i_q <= idx_q;
					end
					idx_q <= idx_q + 1'b1;
				end
			end
			// compaction starts at the removed entry
			if (cmd.shift_start) begin
				idx_q <= best_i_q;
				rd_ok_q <= 1'b0;
			end
			if (cmd.shift_step) begin
				if (!rd_ok_q) rd_ok_q <= 1'b1;
				else idx_q <= idx_q + 1'b1;
			end
			if (cmd.pop) count_q <= count_q - 1'b1;
			if (cmd.enq) begin
				if (st.full) drop_q <= 1'b1;
				else count_q <= count_q + 1'b1;
			end
			if (cmd.append) count_q <= count_q + 1'b1;
		end
	end

	// single table write port
	always_comb begin
		wr_en = 1'b0;
		wr_addr = count_q[IdxW-1:0];
		wr_data = cur_q;
		if (cmd.enq && !st.full) begin
			wr_en = 1'b1;
		end else if (cmd.append) begin
			wr_en = 1'b1;
		end else if (cmd.shift_step && rd_ok_q) begin
			wr_en = 1'b1;
			wr_addr = idx_q[IdxW-1:0];
			wr_data = rd_q;
		end
	end

	// table write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// result composition on finish
	always_comb begin
		picked = sched_q && (st.keep || n_cand != '0);
		pk = st.keep ? cur_q : best_q;
		if (!picked) pk = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				res_q <= {7'd0, count_q, drop_q, sched_q && st.keep, pk.prio, pk.lifespan,
					pk.age, pk.id, picked};
				res_v_q <= 1'b1;
			end else if (res_v_q && out_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = res_v_q;
	assign out_word = res_q;
	assign out_busy = res_v_q && !out_ready;

`ifndef SYNTH
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QueueDepth)) else $error("count overflow");
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> count_q < CntW'(QueueDepth)) else $error("append into full table");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.shift_step && cmd.append)) else $error("shift and append together");
`endif
endmodule

// ===== bench/multi_policy_ready_queue_scheduler_core_tb.sv =====
// testbench for the ready queue scheduler: directed and random words checked against a predictor
module multi_policy_ready_queue_scheduler_core_tb import mpqs_pkg::*; ();

	localparam int LimitCycles = 900000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// action, proc_id, proc_lifespan, proc_age, proc_prio, current_state, pad
	logic [55:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// picked_valid, picked_id, picked_age, picked_lifespan, picked_prio,
	// kept_current, dropped_full, queue_count, pad
	logic [63:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_data;

	multi_policy_ready_queue_scheduler_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor state
	proc_t       table_q[$];
	logic [2:0]  sched_mode;
	logic [55:0] pending_words[$];
	logic [63:0] expected_results[$];
	int          errors;
	int          cycle_count;
	bit          tx_quiet;
	bit          rx_quiet;
	int          rx_hold;
	int          tx_gap;
	int          rx_gap;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// compute the result word for one input word and update the table model
	function automatic logic [63:0] predict_pick(input logic [55:0] w);
		proc_t      cur;
		proc_t      pick;
		proc_t      cand;
		logic [2:0] m;
		logic       live;
		logic       valid;
		logic       kept;
		logic       dropped;
		int         n;
		int         best;
		logic signed [16:0] rb;
		logic signed [16:0] rc;
		cur.id = w[8:1];
		cur.lifespan = w[24:9];
		cur.age = w[40:25];
		cur.prio = w[48:41];
		pick = '0;
		valid = 1'b0;
		kept = 1'b0;
		dropped = 1'b0;
		m = (sched_mode > ModePrio) ? ModeFifo : sched_mode;
		if (!w[0]) begin
			if (table_q.size() < QueueDepth) table_q.push_back(cur);
			else dropped = 1'b1;
		end else begin
			live = (w[50:49] == CurRunning) && (cur.age < cur.lifespan);
			if (live && (m == ModeFifo || m == ModeSjf)) begin
				pick = cur;
				valid = 1'b1;
				kept = 1'b1;
			end else begin
				n = table_q.size() + (live ? 1 : 0);
				best = 0;
				if (n > 0) begin
					pick = (table_q.size() > 0) ? table_q[0] : cur;
					for (int i = 1; i < n; i++) begin
						cand = (i < table_q.size()) ? table_q[i] : cur;
						rb = $signed({1'b0, pick.lifespan}) - $signed({1'b0, pick.age});
						rc = $signed({1'b0, cand.lifespan}) - $signed({1'b0, cand.age});
						if ((m == ModeSjf && cand.lifespan < pick.lifespan) ||
							(m == ModeSrtf && rc < rb) ||
							(m == ModePrio && cand.prio > pick.prio)) begin
							pick = cand;
							best = i;
						end
					end
					valid = 1'b1;
					if (best < table_q.size()) begin
						table_q.delete(best);
						if (live) table_q.push_back(cur);
					end
				end
			end
		end
		predict_pick = {7'd0, 6'(table_q.size()), dropped, kept, pick.prio,
			pick.lifespan, pick.age, pick.id, valid};
	endfunction

	function automatic logic [55:0] make_word(input logic act, input int life_max);
		logic [55:0] w;
		w = '0;
		w[0] = act;
		w[8:1] = 8'($urandom);
		w[24:9] = 16'($urandom_range(0, life_max));
		w[40:25] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, life_max));
		w[48:41] = 8'($urandom);
		w[50:49] = ($urandom_range(0, 3) == 0) ? 2'($urandom) : CurRunning;
		return w;
	endfunction

	// sender: one word per handshake, random gaps unless quiet
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			expected_results.push_back(predict_pick(s_axis_tdata));
			void'(pending_words.pop_front());
		end
		if (tx_gap > 0) begin
			tx_gap <= tx_gap - 1;
			s_axis_tvalid <= 1'b0;
		end else if (pending_words.size() > 0) begin
			if (!tx_quiet && !(s_axis_tvalid && !s_axis_tready) && $urandom_range(0, 15) == 0) begin
				tx_gap <= $urandom_range(1, 19);
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_words[0];
			end
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// long receiver hold countdown
	always @(posedge clk) begin
		if (rx_hold > 0) rx_hold <= rx_hold - 1;
	end

	// receiver: checks each result word against the oldest expectation
	always @(posedge clk) begin
		logic [63:0] exp_w;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result word %h", $time, m_axis_tdata);
				errors++;
			end else begin
				exp_w = expected_results.pop_front();
				if (exp_w !== m_axis_tdata) begin
					$display("%0t mismatch expected %h actual %h", $time, exp_w, m_axis_tdata);
					errors++;
				end
			end
		end
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (!rx_quiet && $urandom_range(0, 15) == 0) begin
			rx_gap <= $urandom_range(1, 19);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LimitCycles) begin
			$display("multi_policy_ready_queue_scheduler_core_tb: FAIL");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (2 * QueueDepth + 20) @(posedge clk);
	endtask

	task automatic write_mode(input logic [2:0] m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sched_mode = m;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [55:0] w;
		errors = 0;
		cycle_count = 0;
		sched_mode = ModeFifo;
		tx_quiet = 0;
		rx_quiet = 0;
		rx_hold = 0;
		tx_gap = 0;
		rx_gap = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: schedule on empty table, field extremes, running current past its lifespan under fifo
		pending_words.push_back({5'd0, CurRunning, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1});
		pending_words.push_back({5'd0, 2'd3, 8'hff, 16'hffff, 16'hffff, 8'hff, 1'b1});
		pending_words.push_back({5'd0, 2'd0, 8'hff, 16'hffff, 16'hffff, 8'hff, 1'b0});
		pending_words.push_back({5'd0, 2'd0, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0});
		pending_words.push_back({5'd0, 2'd0, 8'h12, 16'h0010, 16'h0020, 8'h05, 1'b0});
		pending_words.push_back({5'd0, CurRunning, 8'h33, 16'h0005, 16'h0001, 8'h07, 1'b1});
		pending_words.push_back({5'd0, 2'd2, 8'h34, 16'h0005, 16'h0001, 8'h07, 1'b1});
		wait_drained();

		// directed: fill past full then schedule, under every policy
		for (int p = 0; p < 5; p++) begin
			write_mode(3'(p));
			for (int k = 0; k < QueueDepth + 2; k++)
				pending_words.push_back(make_word(1'b0, 40));
			for (int k = 0; k < 6; k++)
				pending_words.push_back(make_word(1'b1, 40));
			wait_drained();
		end

		// long receiver hold while the sender keeps offering
		rx_hold = 400;
		for (int k = 0; k < 20; k++)
			pending_words.push_back(make_word(1'($urandom_range(0, 1)), 40));
		wait_drained();

		// random phases over all policies including undefined ones
		for (int ph = 0; ph < 16; ph++) begin
			write_mode((ph == 15) ? 3'd7 : 3'($urandom_range(0, 7)));
			if (ph >= 13) begin
				tx_quiet = 1;
				rx_quiet = 1;
			end
			for (int k = 0; k < 90; k++) begin
				w = make_word(($urandom_range(0, 99) < 55) ? 1'b0 : 1'b1,
					($urandom_range(0, 7) == 0) ? 65535 : 60);
				pending_words.push_back(w);
			end
			wait_drained();
		end

		if (errors == 0) begin
			$display("multi_policy_ready_queue_scheduler_core_tb: PASS");
		end else begin
			$display("multi_policy_ready_queue_scheduler_core_tb: FAIL");
		end
		$finish;
	end

endmodule
